/* hw/rtl/overlay_scale_alpha_blend_assert.svh */
// ----------------------------------------------------------------------------
// overlay scale alpha blend assertion macros
// Clocked assertion helpers for the file that checks this block.
// ----------------------------------------------------------------------------
`ifndef OVERLAY_SCALE_ALPHA_BLEND_ASSERT_SVH
`define OVERLAY_SCALE_ALPHA_BLEND_ASSERT_SVH

// same-cycle implication, held off during reset
`define OVSAB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define OVSAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ovsab_pkg.sv */
// ----------------------------------------------------------------------------
// ovsab_pkg
// Shared constants, register indexes and control types of the overlay blender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ovsab_pkg;

    localparam int OVERLAY_SIDE_DEF   = 256;
    localparam int MAX_FRAME_SIDE_DEF = 4096;

    // field widths
    localparam int ADDR_IN_W    = 16;
    localparam int PIX_W        = 8;
    localparam int FRAME_REG_W  = 13;
    localparam int OV_REG_W     = 9;
    localparam int ALPHA_REG_W  = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // fixed point
    localparam int FRAC_BITS    = 16;
    localparam int BLEND_SHIFT  = 8;
    localparam int ALPHA_W      = 9;
    localparam int ALPHA_ONE    = 256;
    localparam logic [PIX_W-1:0] TRANSPARENT_TEXEL = 8'd255;

    // opcodes
    localparam logic OP_TEXEL_WRITE = 1'b0;
    localparam logic OP_COMPOSITE   = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAY_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAY_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA    = 3'd4;

    // register reset values
    localparam logic [FRAME_REG_W-1:0] FRAME_WIDTH_RST    = 13'd640;
    localparam logic [FRAME_REG_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
    localparam logic [OV_REG_W-1:0]    OVERLAY_WIDTH_RST  = 9'd256;
    localparam logic [OV_REG_W-1:0]    OVERLAY_HEIGHT_RST = 9'd256;
    localparam logic signed [ALPHA_REG_W-1:0] BLEND_ALPHA_RST = 16'sd128;

    typedef struct packed {
        logic cfg_write;
        logic div_start;
        logic div_sel_y;
        logic step_load;
        logic tx_write;
        logic px_accept;
        logic addr_load;
        logic rd_en;
        logic blend_load;
        logic out_load;
    } ovsab_cmd_t;

    typedef struct packed {
        logic div_done;
    } ovsab_status_t;

endpackage

/* hw/rtl/ovsab_ram.sv */
// ----------------------------------------------------------------------------
// ovsab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovsab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ovsab_div.sv */
// ----------------------------------------------------------------------------
// ovsab_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovsab_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] nq_reg, nq_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial      = {rem_reg, nq_reg[NUM_W-1]};
        diff       = trial - {1'b0, den_reg};
        ge         = (trial >= {1'b0, den_reg});
        count_next = count_reg;
        done_next  = 1'b0;
        nq_next    = nq_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (start)
        begin
            count_next = CW'(NUM_W);
            nq_next    = num;
            rem_next   = '0;
            den_next   = den;
        end
        else if (count_reg != '0)
        begin
            // remainder stays below the divisor, so it fits DEN_W bits
            rem_next   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next    = {nq_reg[NUM_W-2:0], ge};
            count_next = count_reg - CW'(1);
            done_next  = (count_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

/* hw/rtl/ovsab_ctrl.sv */
// ----------------------------------------------------------------------------
// ovsab_ctrl
// Sequencer: scale derivation after reset and writes, pixel steps, handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovsab_ctrl import ovsab_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          opcode,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    output logic          out_valid,
    input  logic          out_stall,
    input  ovsab_status_t status,
    output ovsab_cmd_t    cmd
);

    localparam logic [3:0] S_DIVX  = 4'd0;
    localparam logic [3:0] S_WAITX = 4'd1;
    localparam logic [3:0] S_DIVY  = 4'd2;
    localparam logic [3:0] S_WAITY = 4'd3;
    localparam logic [3:0] S_IDLE  = 4'd4;
    localparam logic [3:0] S_ADDR  = 4'd5;
    localparam logic [3:0] S_READ  = 4'd6;
    localparam logic [3:0] S_BLEND = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;
    logic       cfg_accept;
    logic       out_free;

    assign cfg_ready  = (state_reg == S_IDLE);
    // a pending config write wins over a request in the same cycle
    assign in_stall   = (state_reg != S_IDLE) || cfg_valid;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.cfg_write  = cfg_accept;
        cmd.tx_write   = in_accept && (opcode == OP_TEXEL_WRITE);
        cmd.px_accept  = in_accept && (opcode == OP_COMPOSITE);
        unique case (state_reg)
            S_DIVX:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAITX;
            end
            S_WAITX:
            begin
                if (status.div_done)
                begin
                    cmd.step_load = 1'b1;
                    state_next    = S_DIVY;
                end
            end
            S_DIVY:
            begin
                cmd.div_sel_y = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_WAITY;
            end
            S_WAITY:
            begin
                cmd.div_sel_y = 1'b1;
                if (status.div_done)
                begin
                    cmd.step_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_accept)
                begin
                    state_next = S_DIVX;
                end
                else if (cmd.px_accept)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.addr_load = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.blend_load = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_DIVX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DIVX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/ovsab_datapath.sv */
// ----------------------------------------------------------------------------
// ovsab_datapath
// Config registers, raster counters, overlay sampling, store and blend stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovsab_datapath import ovsab_pkg::*; #(
    parameter int OVERLAY_SIDE   = OVERLAY_SIDE_DEF,
    parameter int MAX_FRAME_SIDE = MAX_FRAME_SIDE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ovsab_cmd_t             cmd,
    output ovsab_status_t          status,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [ADDR_IN_W-1:0]   texel_address,
    input  logic [PIX_W-1:0]       texel_value,
    input  logic [PIX_W-1:0]       source_pixel,
    output logic [PIX_W-1:0]       out_pixel,
    output logic                   frame_last
);

    localparam int OW_W   = $clog2(OVERLAY_SIDE + 1);
    localparam int OX_W   = $clog2(OVERLAY_SIDE);
    localparam int FW_W   = $clog2(MAX_FRAME_SIDE + 1);
    localparam int CNT_W  = $clog2(MAX_FRAME_SIDE);
    localparam int STEP_W = OW_W + FRAC_BITS;
    localparam int PROD_W = CNT_W + STEP_W;
    localparam int C_W    = PROD_W - FRAC_BITS;
    localparam int DEPTH  = OVERLAY_SIDE * OVERLAY_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIN_W  = OX_W + OW_W + 1;
    localparam int MUL_W  = PIX_W + ALPHA_W;

    logic [FRAME_REG_W-1:0]        frame_width_reg, frame_height_reg;
    logic [OV_REG_W-1:0]           overlay_width_reg, overlay_height_reg;
    logic signed [ALPHA_REG_W-1:0] blend_alpha_reg;

    logic [FW_W-1:0]   fw, fh;
    logic [OW_W-1:0]   ow, oh;
    logic [ALPHA_W-1:0] alpha, alpha_inv;

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [FW_W:0]     col_inc, row_inc;
    logic              row_end, last;

    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic [STEP_W-1:0] div_num;
    logic [FW_W-1:0]   div_den;
    logic [STEP_W-1:0] div_quo;

    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [PIX_W-1:0]  src_reg;
    logic              last_reg;
    logic [C_W-1:0]    cx, cy, ox_full, oy_full;
    logic [OX_W-1:0]   ox, oy;
    logic [LIN_W-1:0]  lin_addr;
    logic [ADDR_W-1:0] addr_reg;

    logic              tx_we;
    logic [PIX_W-1:0]  texel;
    logic [MUL_W-1:0]  mul_a_reg, mul_b_reg;
    logic              transp_reg;
    logic [MUL_W:0]    blend_sum;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              frame_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            overlay_width_reg  <= OVERLAY_WIDTH_RST;
            overlay_height_reg <= OVERLAY_HEIGHT_RST;
            blend_alpha_reg    <= BLEND_ALPHA_RST;
        end
        else if (cmd.cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[FRAME_REG_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[FRAME_REG_W-1:0];
                REG_OVERLAY_WIDTH:  overlay_width_reg  <= cfg_data[OV_REG_W-1:0];
                REG_OVERLAY_HEIGHT: overlay_height_reg <= cfg_data[OV_REG_W-1:0];
                REG_BLEND_ALPHA:    blend_alpha_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sizes saturate to 1..max, alpha to 0..256
    always_comb
    begin
        if (frame_width_reg == '0)
            fw = FW_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_FRAME_SIDE))
            fw = FW_W'(MAX_FRAME_SIDE);
        else
            fw = FW_W'(frame_width_reg);

        if (frame_height_reg == '0)
            fh = FW_W'(1);
        else if (32'(frame_height_reg) > 32'(MAX_FRAME_SIDE))
            fh = FW_W'(MAX_FRAME_SIDE);
        else
            fh = FW_W'(frame_height_reg);

        if (overlay_width_reg == '0)
            ow = OW_W'(1);
        else if (32'(overlay_width_reg) > 32'(OVERLAY_SIDE))
            ow = OW_W'(OVERLAY_SIDE);
        else
            ow = OW_W'(overlay_width_reg);

        if (overlay_height_reg == '0)
            oh = OW_W'(1);
        else if (32'(overlay_height_reg) > 32'(OVERLAY_SIDE))
            oh = OW_W'(OVERLAY_SIDE);
        else
            oh = OW_W'(overlay_height_reg);

        if (blend_alpha_reg[ALPHA_REG_W-1])
            alpha = '0;
        else if (32'(blend_alpha_reg[ALPHA_REG_W-2:0]) > 32'(ALPHA_ONE))
            alpha = ALPHA_W'(ALPHA_ONE);
        else
            alpha = blend_alpha_reg[ALPHA_W-1:0];
        alpha_inv = ALPHA_W'(ALPHA_ONE) - alpha;
    end

    // scale factors through the shared divider
    assign div_num = cmd.div_sel_y ? (STEP_W'(oh) << FRAC_BITS) : (STEP_W'(ow) << FRAC_BITS);
    assign div_den = cmd.div_sel_y ? fh : fw;

    ovsab_div #(
        .NUM_W (STEP_W),
        .DEN_W (FW_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (status.div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.step_load)
        begin
            if (cmd.div_sel_y)
                step_y_reg <= div_quo;
            else
                step_x_reg <= div_quo;
        end
    end

    // raster counters
    always_comb
    begin
        col_inc  = (FW_W + 1)'(col_reg) + (FW_W + 1)'(1);
        row_inc  = (FW_W + 1)'(row_reg) + (FW_W + 1)'(1);
        row_end  = (col_inc >= (FW_W + 1)'(fw));
        last     = row_end && (row_inc >= (FW_W + 1)'(fh));
        col_next = row_end ? '0 : col_inc[CNT_W-1:0];
        if (!row_end)
            row_next = row_reg;
        else if (last)
            row_next = '0;
        else
            row_next = row_inc[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.px_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // sample position, taken from the counters before they advance
    always_ff @(posedge clk)
    begin
        if (cmd.px_accept)
        begin
            prod_x_reg <= col_reg * step_x_reg;
            prod_y_reg <= row_reg * step_y_reg;
            src_reg    <= source_pixel;
            last_reg   <= last;
        end
    end

    always_comb
    begin
        cx       = prod_x_reg[PROD_W-1:FRAC_BITS];
        cy       = prod_y_reg[PROD_W-1:FRAC_BITS];
        ox_full  = (cx >= C_W'(ow)) ? C_W'(ow - OW_W'(1)) : cx;
        oy_full  = (cy >= C_W'(oh)) ? C_W'(oh - OW_W'(1)) : cy;
        ox       = ox_full[OX_W-1:0];
        oy       = oy_full[OX_W-1:0];
        lin_addr = LIN_W'(oy * ow) + LIN_W'(ox);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr_load)
        begin
            addr_reg <= lin_addr[ADDR_W-1:0];
        end
    end

    // overlay store, writes beyond the store are dropped
    assign tx_we = cmd.tx_write && (32'(texel_address) < 32'(DEPTH));

    ovsab_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (tx_we),
        .waddr (ADDR_W'(texel_address)),
        .wdata (texel_value),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (texel)
    );

    // blend
    always_ff @(posedge clk)
    begin
        if (cmd.blend_load)
        begin
            mul_a_reg  <= texel * alpha;
            mul_b_reg  <= src_reg * alpha_inv;
            transp_reg <= (texel == TRANSPARENT_TEXEL);
        end
    end

    assign blend_sum = (MUL_W + 1)'(mul_a_reg) + (MUL_W + 1)'(mul_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pixel_reg  <= transp_reg ? src_reg : PIX_W'(blend_sum >> BLEND_SHIFT);
            frame_last_reg <= last_reg;
        end
    end

    assign out_pixel  = out_pixel_reg;
    assign frame_last = frame_last_reg;

endmodule

/* hw/rtl/overlay_scale_alpha_blend.sv */
// ----------------------------------------------------------------------------
// overlay_scale_alpha_blend
// Scaled, alpha-blended overlay composited onto a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid / in_stall) carries texel writes (opcode 0) and
//   source pixels (opcode 1) in raster order; output channel (out_valid /
//   out_stall) returns one composited pixel per source pixel, frame_last
//   marking the final pixel of a frame
// - config channel (cfg_valid / cfg_ready) writes the size and alpha
//   registers by index; it is ready only while the block is idle
// - texel writes can be accepted every cycle while no config write is pending
// - a source pixel steps through sample multiply, address multiply, store read,
//   blend multiply and output load before the next request is taken
// - the result sits in an output register, so the next request is taken
//   while it waits; a stalled receiver holds the block in its output step
// - after reset and after every config write the shared bit-serial divider
//   derives both scale factors, during which the input channel stalls
// - reset clears counters and control state; the overlay store is not
//   cleared and must be loaded before it is sampled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "overlay_scale_alpha_blend_assert.svh"

module overlay_scale_alpha_blend import ovsab_pkg::*; #(
    parameter int OVERLAY_SIDE   = OVERLAY_SIDE_DEF,
    parameter int MAX_FRAME_SIDE = MAX_FRAME_SIDE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [ADDR_IN_W-1:0]   texel_address,
    input  logic [PIX_W-1:0]       texel_value,
    input  logic [PIX_W-1:0]       source_pixel,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIX_W-1:0]       out_pixel,
    output logic                   frame_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ovsab_cmd_t    cmd;
    ovsab_status_t status;

    ovsab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ovsab_datapath #(
        .OVERLAY_SIDE   (OVERLAY_SIDE),
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .texel_address (texel_address),
        .texel_value   (texel_value),
        .source_pixel  (source_pixel),
        .out_pixel     (out_pixel),
        .frame_last    (frame_last)
    );

    // a pixel in flight blocks further requests
    `OVSAB_ASSERT_NEXT(a_px_busy, clk, rst_n, cmd.px_accept, in_stall,
        "pixel accepted but input not stalled")
    // a config write restarts the scale derivation
    `OVSAB_ASSERT_NEXT(a_cfg_rederive, clk, rst_n, cmd.cfg_write, cmd.div_start && in_stall,
        "config write did not start scale derivation")
    // loading the output register always presents a result
    `OVSAB_ASSERT_NEXT(a_out_load, clk, rst_n, cmd.out_load, out_valid,
        "result loaded but not presented")
    // the output register is never overwritten while its result is held
    `OVSAB_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.out_load, !(out_valid && out_stall),
        "output register overwritten while stalled")

endmodule
